FILE: design/cbp_pkg.sv
// ----------------------------------------------------------------------------
// cbp_pkg
// Shared types and constants for the cell burst pacer.
// ----------------------------------------------------------------------------
package cbp_pkg;

  typedef logic [15:0] channel_t;
  typedef logic [15:0] cfg_word_t;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_CELL_SPACING = 1'b0,
    REG_BURST_LENGTH = 1'b1
  } cfg_reg_t;

  // input kind carried on s_tuser
  typedef enum logic [0:0] {
    FUNC_TICK    = 1'b0,
    FUNC_REQUEST = 1'b1
  } func_t;

  localparam cfg_word_t CELL_SPACING_RST = 16'd15;
  localparam cfg_word_t BURST_LENGTH_RST = 16'd172;

endpackage

FILE: design/cell_burst_pacer_top.sv
// a cell or drop flag caused by an input appears on m_* in the cycle after it is taken
// throughput: one input per cycle; s_tready drops only while a result waits on m_tready low
// the request queue is a memory with a registered read of the head entry
// reset (rst, synchronous): queue empty, no burst running, registers back to
// spacing 15 and length 172; the queue memory itself is not cleared
// ----------------------------------------------------------------------------
// cell_burst_pacer_top
// Queues burst requests and sends each as a paced burst of cells on tick inputs.
// ----------------------------------------------------------------------------
module cell_burst_pacer_top #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  // input stream
  input  logic                s_tvalid,
  output logic                s_tready,
  input  cbp_pkg::channel_t   s_tdata,   // [15:0] req_channel
  input  logic                s_tuser,   // [0] func
  // result stream
  output logic                m_tvalid,
  input  logic                m_tready,
  output cbp_pkg::channel_t   m_tdata,   // [15:0] cell_channel
  output logic                m_tuser,   // [0] dropped
  // configuration writes
  input  logic                cfg_we,
  input  cbp_pkg::cfg_reg_t   cfg_index,
  input  cbp_pkg::cfg_word_t  cfg_data
);
  import cbp_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  // configuration
  cfg_word_t cell_spacing;
  cfg_word_t burst_length;

  // queue and burst state
  channel_t          queue_mem [QUEUE_DEPTH];
  channel_t          head_data;
  channel_t          hold_channel;
  logic              use_hold, use_hold_next;
  logic [CNT_W-1:0]  fifo_count, fifo_count_next;
  logic [PTR_W-1:0]  read_ptr, read_ptr_next;
  logic [PTR_W-1:0]  write_ptr, write_ptr_next;
  logic [15:0]       tick_countdown, tick_countdown_next;
  logic [15:0]       cells_sent, cells_sent_next;

  logic              accept;
  logic              is_req;
  logic              fifo_wr;
  logic              res_valid;
  logic              res_dropped;
  channel_t          res_channel;
  channel_t          burst_channel;

  assign s_tready      = !m_tvalid || m_tready;
  assign accept        = s_tvalid && s_tready;
  assign is_req        = (func_t'(s_tuser) == FUNC_REQUEST);
  // head entry just written into an empty queue is not yet in head_data
  assign burst_channel = use_hold ? hold_channel : head_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_spacing <= CELL_SPACING_RST;
      burst_length <= BURST_LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CELL_SPACING: cell_spacing <= cfg_data;
        REG_BURST_LENGTH: burst_length <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    fifo_count_next     = fifo_count;
    read_ptr_next       = read_ptr;
    write_ptr_next      = write_ptr;
    tick_countdown_next = tick_countdown;
    cells_sent_next     = cells_sent;
    use_hold_next       = use_hold;
    fifo_wr             = 1'b0;
    res_valid           = 1'b0;
    res_dropped         = 1'b0;
    res_channel         = burst_channel;

    if (accept) begin
      if (is_req) begin
        if (fifo_count == CNT_FULL) begin
          res_valid   = 1'b1;
          res_dropped = 1'b1;
          res_channel = s_tdata;
        end else begin
          fifo_wr         = 1'b1;
          write_ptr_next  = ptr_inc(write_ptr);
          fifo_count_next = fifo_count + CNT_W'(1);
          if (fifo_count == '0) begin
            use_hold_next       = 1'b1;
            cells_sent_next     = '0;
            tick_countdown_next = cell_spacing;
          end
        end
      end else if (fifo_count != '0) begin
        if (tick_countdown > 16'd1) begin
          tick_countdown_next = tick_countdown - 16'd1;
        end else begin
          res_valid = 1'b1;
          if (({1'b0, cells_sent} + 17'd1) < {1'b0, burst_length}) begin
            cells_sent_next     = cells_sent + 16'd1;
            tick_countdown_next = cell_spacing;
          end else begin
            read_ptr_next   = ptr_inc(read_ptr);
            fifo_count_next = fifo_count - CNT_W'(1);
            use_hold_next   = 1'b0;
            cells_sent_next = '0;
            if (fifo_count != CNT_W'(1)) begin
              tick_countdown_next = cell_spacing;
            end else begin
              tick_countdown_next = '0;
            end
          end
        end
      end
    end
  end

  // queue memory, head entry read ahead through the next pointer
  always_ff @(posedge clk) begin
    if (fifo_wr) begin
      queue_mem[write_ptr] <= s_tdata;
    end
    head_data <= queue_mem[read_ptr_next];
  end

  // only a request into an empty queue becomes the held head
  always_ff @(posedge clk) begin
    if (fifo_wr && (fifo_count == '0)) begin
      hold_channel <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_count     <= '0;
      read_ptr       <= '0;
      write_ptr      <= '0;
      tick_countdown <= '0;
      cells_sent     <= '0;
      use_hold       <= 1'b0;
    end else begin
      fifo_count     <= fifo_count_next;
      read_ptr       <= read_ptr_next;
      write_ptr      <= write_ptr_next;
      tick_countdown <= tick_countdown_next;
      cells_sent     <= cells_sent_next;
      use_hold       <= use_hold_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      m_tdata <= res_channel;
      m_tuser <= res_dropped;
    end
  end

endmodule

FILE: design/cbp_checker.sv
// ----------------------------------------------------------------------------
// cbp_checker
// Port-level checks on the cell burst pacer, bound to the top level.
// ----------------------------------------------------------------------------
module cbp_checker (
  input logic              clk,
  input logic              rst,
  input logic              s_tvalid,
  input logic              s_tready,
  input logic              m_tvalid,
  input logic              m_tready,
  input cbp_pkg::channel_t m_tdata,
  input logic              m_tuser
);
  import cbp_pkg::*;

  // a stalled result stays up
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // input side only stalls behind a waiting result
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty result register");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result present after reset");

  // every new result comes from an input taken the cycle before
  a_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
    else $error("result without an accepted input");

endmodule

bind cell_burst_pacer_top cbp_checker u_cbp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cell burst pacer. Ticks and burst requests go in
// on the input stream. A model of the request queue and the burst pacing
// predicts every cell and every drop flag, and each one is compared as it
// leaves. Both stream sides stall at random, except in the final stretch.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cbp_pkg::*;

  localparam int QDEPTH = 16;

  typedef struct packed {
    channel_t chan;
    logic     dropped;
  } cell_result_t;

  logic      clk = 1'b0;
  logic      rst;
  logic      s_tvalid;
  logic      s_tready;
  channel_t  s_tdata;
  logic      s_tuser;
  logic      m_tvalid;
  logic      m_tready;
  channel_t  m_tdata;
  logic      m_tuser;
  logic      cfg_we;
  cfg_reg_t  cfg_index;
  cfg_word_t cfg_data;

  // pacing model state
  cell_result_t expected_cells[$];
  channel_t     queued_requests[$];   // head is the active burst
  cfg_word_t    spacing_q = CELL_SPACING_RST;
  cfg_word_t    length_q  = BURST_LENGTH_RST;
  logic [15:0]  countdown = '0;
  logic [15:0]  sent_cnt  = '0;

  int mismatches = 0;
  bit rx_stalls_on = 1'b1;

  cell_burst_pacer_top #(.QUEUE_DEPTH(QDEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // advance the model by one accepted request or tick
  function automatic void pace_model(func_t f, channel_t ch);
    if (f == FUNC_REQUEST) begin
      if (queued_requests.size() >= QDEPTH) begin
        expected_cells.push_back('{chan: ch, dropped: 1'b1});
      end else begin
        queued_requests.push_back(ch);
        if (queued_requests.size() == 1) begin
          sent_cnt  = '0;
          countdown = spacing_q;
        end
      end
    end else if (queued_requests.size() != 0) begin
      if (countdown > 16'd1) begin
        countdown = countdown - 16'd1;
      end else begin
        expected_cells.push_back('{chan: queued_requests[0], dropped: 1'b0});
        // zero length behaves as one; a shortened length ends the burst on its next cell
        if (int'(sent_cnt) + 1 < int'(length_q)) begin
          sent_cnt  = sent_cnt + 16'd1;
          countdown = spacing_q;
        end else begin
          void'(queued_requests.pop_front());
          sent_cnt  = '0;
          countdown = (queued_requests.size() != 0) ? spacing_q : 16'd0;
        end
      end
    end
  endfunction

  // valid stays high from one item to the next; only gaps lower it
  task automatic send_item(func_t f, channel_t ch);
    s_tvalid <= 1'b1;
    s_tuser  <= f;
    s_tdata  <= ch;
    do @(posedge clk); while (!s_tready);
    pace_model(f, ch);
  endtask

  task automatic hold_off(int unsigned cycles);
    s_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, cfg_word_t val);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CELL_SPACING: spacing_q = val;
      REG_BURST_LENGTH: length_q  = val;
      default: ;
    endcase
  endtask

  task automatic run_phase(int n_items, int req_pct, bit gaps_on);
    func_t    f;
    channel_t ch;
    int       pick;
    for (int k = 0; k < n_items; k++) begin
      f    = ($urandom_range(0, 99) < req_pct) ? FUNC_REQUEST : FUNC_TICK;
      pick = $urandom_range(0, 9);
      ch   = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : channel_t'($urandom);
      send_item(f, ch);
      if (gaps_on && $urandom_range(0, 5) == 0) hold_off($urandom_range(1, 15));
    end
  endtask

  // zero spacing and length, idle tick, queue filled to the brim, drops
  task automatic test_fill_and_drop();
    write_reg(REG_CELL_SPACING, 16'd0);
    write_reg(REG_BURST_LENGTH, 16'd0);
    send_item(FUNC_TICK, 16'hFFFF);
    for (int i = 0; i < QDEPTH; i++) begin
      send_item(FUNC_REQUEST, (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF :
                ((i % 2) ? 16'hAAAA : 16'h5555) ^ channel_t'(i));
    end
    send_item(FUNC_REQUEST, 16'hFFFF);
    send_item(FUNC_REQUEST, 16'h0000);
    send_item(FUNC_TICK, 16'h0000);
    send_item(FUNC_TICK, 16'h8001);
  endtask

  // length cut to the cells already sent ends the burst on its next cell
  task automatic test_register_change_midburst();
    write_reg(REG_BURST_LENGTH, 16'd2);
    write_reg(REG_CELL_SPACING, 16'd2);
    send_item(FUNC_TICK, 16'h1234);
    send_item(FUNC_TICK, 16'hEDCB);
    write_reg(REG_BURST_LENGTH, 16'd1);
    write_reg(REG_CELL_SPACING, 16'd3);
    send_item(FUNC_TICK, 16'h0F0F);
  endtask

  task automatic test_random_traffic();
    write_reg(REG_CELL_SPACING, 16'd1);
    write_reg(REG_BURST_LENGTH, 16'd1);
    run_phase(100, 30, 1'b1);
    write_reg(REG_CELL_SPACING, 16'd2);
    write_reg(REG_BURST_LENGTH, 16'd3);
    run_phase(130, 25, 1'b1);
    write_reg(REG_CELL_SPACING, 16'd0);
    write_reg(REG_BURST_LENGTH, 16'd4);
    run_phase(100, 20, 1'b0);
    repeat (3) begin
      write_reg(REG_CELL_SPACING, cfg_word_t'($urandom_range(0, 5)));
      write_reg(REG_BURST_LENGTH, cfg_word_t'($urandom_range(0, 6)));
      run_phase(60, $urandom_range(10, 40), 1'b1);
    end
  endtask

  // one endless burst lets the queue overflow, then a short length cuts it off
  task automatic test_long_burst_overflow();
    write_reg(REG_CELL_SPACING, 16'd1);
    write_reg(REG_BURST_LENGTH, 16'd65535);
    run_phase(80, 40, 1'b1);
    write_reg(REG_BURST_LENGTH, 16'd1);
    run_phase(100, 15, 1'b1);
  endtask

  task automatic test_quiet_finish();
    rx_stalls_on = 1'b0;
    write_reg(REG_CELL_SPACING, 16'd1);
    write_reg(REG_BURST_LENGTH, 16'd2);
    run_phase(110, 35, 1'b0);
    // widest spacing last, since a loaded countdown would stall later phases
    write_reg(REG_CELL_SPACING, 16'd65535);
    run_phase(40, 50, 1'b0);
  endtask

  // result side: random stall bursts while enabled
  initial begin
    m_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (rx_stalls_on && $urandom_range(0, 2) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    cell_result_t exp_cell;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_cells.size() == 0) begin
        $display("%0t: unexpected result channel %h dropped %b", $time, m_tdata, m_tuser);
        mismatches++;
      end else begin
        exp_cell = expected_cells.pop_front();
        if (m_tdata !== exp_cell.chan) begin
          $display("%0t: cell_channel expected %h actual %h", $time, exp_cell.chan, m_tdata);
          mismatches++;
        end
        if (m_tuser !== exp_cell.dropped) begin
          $display("%0t: dropped expected %b actual %b", $time, exp_cell.dropped, m_tuser);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= FUNC_TICK;
    cfg_we    <= 1'b0;
    cfg_index <= REG_CELL_SPACING;
    cfg_data  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_fill_and_drop();
    test_register_change_midburst();
    test_random_traffic();
    test_long_burst_overflow();
    test_quiet_finish();

    settle();
    if (mismatches == 0) begin
      $display("PASS cell_burst_pacer_top");
    end else begin
      $display("FAIL cell_burst_pacer_top");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("FAIL cell_burst_pacer_top");
    $finish;
  end

endmodule
